[rtl/arena_bump_allocator_top_assert.svh]
// Assertion macros shared by the arena bump allocator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ARENA_BUMP_ALLOCATOR_TOP_ASSERT_SVH
`define ARENA_BUMP_ALLOCATOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

`define ABA_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
        else $error(msg);

`define ABA_ASSERT_NEXT(lbl, ck, rn, pre, post, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
        else $error(msg);

`else

`define ABA_ASSERT(lbl, ck, rn, prop, msg)

`define ABA_ASSERT_NEXT(lbl, ck, rn, pre, post, msg)

`endif

`endif

[rtl/aba_pkg.sv]
// Shared types, codes and constants of the arena bump allocator.
// Depends on nothing; used by aba_ctrl, aba_datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package aba_pkg;

    localparam int          DEF_MAX_BLOCKS = 16;
    localparam int          DEF_MAX_ALIGN  = 16;
    localparam logic [31:0] DEF_MAX_ALLOC  = 32'hFFFF_FFFF;

    localparam int          SIZE_W = 32;
    localparam int          TOT_W  = 37;
    localparam int          BIDX_W = 4;

    localparam logic [31:0] BLOCK_SIZE_RST = 32'd4096;

    // Configuration space: one 32-bit register per word.
    localparam int          PADDR_W        = 3;
    localparam logic [0:0]  REG_BLOCK_SIZE = 1'b0;

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_REWIND  = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_NONE    = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ALIGN = 2'd1,
        ST_LIMIT = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_NORM,
        S_SCAN
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PREP,
        OP_SCAN,
        OP_REWIND,
        OP_RELEASE,
        OP_NOP,
        OP_ALIGN_ERR,
        OP_GRANT,
        OP_FRESH,
        OP_LIMIT_ERR,
        OP_FULL_ERR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        req_type_t req_type;
        logic      align_bad;
        logic      hit;
        logic      scan_done;
        logic      too_big;
        logic      table_full;
    } dp_sts_t;

endpackage

`default_nettype wire

[rtl/aba_ctrl.sv]
// Sequencer of the arena bump allocator: decode, block scan and commit.
// Depends on aba_pkg and arena_bump_allocator_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "arena_bump_allocator_top_assert.svh"

module aba_ctrl (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              start,
    output logic             busy,
    output logic             done,
    output aba_pkg::dp_cmd_t cmd,
    input  aba_pkg::dp_sts_t sts
);
    import aba_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        done_reg;
    logic        done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                case (sts.req_type)
                    REQ_ALLOC:
                    begin
                        if (sts.align_bad)
                        begin
                            cmd.op = OP_ALIGN_ERR;
                        end
                        else
                        begin
                            cmd.op     = OP_PREP;
                            state_next = S_SCAN;
                            done_next  = 1'b0;
                        end
                    end
                    REQ_REWIND:  cmd.op = OP_REWIND;
                    REQ_RELEASE: cmd.op = OP_RELEASE;
                    default:     cmd.op = OP_NOP;
                endcase
            end
            S_SCAN:
            begin
                if (sts.hit)
                begin
                    cmd.op     = OP_GRANT;
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else if (sts.scan_done)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    if (sts.too_big)
                    begin
                        cmd.op = OP_LIMIT_ERR;
                    end
                    else if (sts.table_full)
                    begin
                        cmd.op = OP_FULL_ERR;
                    end
                    else
                    begin
                        cmd.op = OP_FRESH;
                    end
                end
                else
                begin
                    cmd.op = OP_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    `ABA_ASSERT_NEXT(a_norm_after_accept, clk, rst_n, start && !busy, state_reg == S_NORM, "accept did not enter decode")
    `ABA_ASSERT(a_done_from_work, clk, rst_n, done_reg |-> $past(state_reg) != S_IDLE, "result without work")
    `ABA_ASSERT_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg, "result strobe longer than one cycle")

endmodule

`default_nettype wire

[rtl/aba_datapath.sv]
// Datapath of the arena bump allocator: request registers, block tables,
// three-stage scan pipeline, totals and result registers.
// Depends on aba_pkg and arena_bump_allocator_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "arena_bump_allocator_top_assert.svh"

module aba_datapath #(
    parameter int          MAX_BLOCKS = aba_pkg::DEF_MAX_BLOCKS,
    parameter int          MAX_ALIGN  = aba_pkg::DEF_MAX_ALIGN,
    parameter logic [31:0] MAX_ALLOC  = aba_pkg::DEF_MAX_ALLOC
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  aba_pkg::dp_cmd_t              cmd,
    output aba_pkg::dp_sts_t              sts,
    input  wire [1:0]                     req_type,
    input  wire [aba_pkg::SIZE_W-1:0]     req_size,
    input  wire [aba_pkg::SIZE_W-1:0]     req_align,
    input  wire [aba_pkg::SIZE_W-1:0]     block_size,
    output aba_pkg::status_t              status,
    output logic [aba_pkg::BIDX_W-1:0]    block_index,
    output logic [aba_pkg::SIZE_W-1:0]    region_offset,
    output logic [aba_pkg::TOT_W-1:0]     bytes_in_use,
    output logic [aba_pkg::TOT_W-1:0]     total_capacity
);
    import aba_pkg::*;

    localparam int          IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int          CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int          ALIGN_LOG  = $clog2(MAX_ALIGN + 1) - 1;
    // Largest power of two that does not exceed the alignment limit.
    localparam logic [31:0] ALIGN_CAP  = 32'(1) << ALIGN_LOG;
    localparam logic [31:0] MAX_ALIGN_W = 32'(MAX_ALIGN);

    // Request registers.
    req_type_t          type_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [SIZE_W-1:0]  align_reg;
    logic [SIZE_W-1:0]  mask_reg;
    logic [SIZE_W-1:0]  want_reg;

    // Allocator state.
    logic [CNT_W-1:0]      open_reg,   open_next;
    logic [IDX_W-1:0]      active_reg, active_next;
    logic [TOT_W-1:0]      used_reg,   used_next;
    logic [TOT_W-1:0]      captot_reg, captot_next;
    logic [MAX_BLOCKS-1:0] fv_reg,     fv_next;

    // Scan pipeline.
    logic [CNT_W-1:0]  scan_addr_reg, scan_addr_next;
    logic              v1_reg, v1_next;
    logic              v2_reg, v2_next;
    logic [SIZE_W-1:0] cap1_reg;
    logic [SIZE_W-1:0] fill1_reg;
    logic              fv1_reg;
    logic [IDX_W-1:0]  idx1_reg;
    logic [SIZE_W-1:0] o2_reg;
    logic [SIZE_W-1:0] cap2_reg;
    logic [IDX_W-1:0]  idx2_reg;

    // Block tables.
    logic [SIZE_W-1:0] cap_mem  [MAX_BLOCKS];
    logic [SIZE_W-1:0] fill_mem [MAX_BLOCKS];

    // Result registers.
    status_t           status_reg;
    logic [IDX_W-1:0]  bidx_reg;
    logic [SIZE_W-1:0] off_reg;

    logic [SIZE_W-1:0] mask_calc;
    logic [SIZE_W-1:0] want_calc;
    logic [SIZE_W:0]   align_sum;
    logic [SIZE_W-1:0] o_calc;
    logic [SIZE_W+1:0] end_sum;
    logic              addr_done;
    logic              hit;
    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W-1:0]  new_idx;
    logic              fill_wr_en;
    logic [IDX_W-1:0]  fill_wr_addr;
    logic [SIZE_W-1:0] fill_wr_data;
    logic [IDX_W+3:0]  bidx_ext;

    // Alignment mask: next power of two of the alignment, minus one.
    always_comb
    begin
        logic [SIZE_W-1:0] sm;
        sm = align_reg - 32'd1;
        sm = sm | (sm >> 1);
        sm = sm | (sm >> 2);
        sm = sm | (sm >> 4);
        sm = sm | (sm >> 8);
        sm = sm | (sm >> 16);
        mask_calc = (align_reg <= 32'd1) ? '0 : sm;
    end

    // Size of a fresh block: the default capacity, raised to the alignment
    // limit, or the request if that is larger.
    always_comb
    begin
        logic [SIZE_W-1:0] dflt;
        dflt      = (block_size < MAX_ALIGN_W) ? MAX_ALIGN_W : block_size;
        want_calc = (dflt > size_reg) ? dflt : size_reg;
    end

    assign rd_idx    = scan_addr_reg[IDX_W-1:0];
    assign new_idx   = open_reg[IDX_W-1:0];
    assign addr_done = (scan_addr_reg >= open_reg);

    // Stage two input: fill level aligned up, saturating on overflow.
    assign align_sum = {1'b0, (fv1_reg ? fill1_reg : {SIZE_W{1'b0}})} + {1'b0, mask_reg};
    assign o_calc    = align_sum[SIZE_W] ? '1 : (align_sum[SIZE_W-1:0] & ~mask_reg);

    // A saturated offset never fits because the size is at least one.
    assign end_sum = {2'b00, o2_reg} + {2'b00, size_reg};
    assign hit     = v2_reg && (end_sum <= {2'b00, cap2_reg});

    assign sts.req_type   = type_reg;
    assign sts.align_bad  = (align_reg > ALIGN_CAP);
    assign sts.hit        = hit;
    assign sts.scan_done  = !v1_reg && !v2_reg && addr_done;
    assign sts.too_big    = (want_reg > MAX_ALLOC);
    assign sts.table_full = (open_reg >= CNT_W'(MAX_BLOCKS));

    always_comb
    begin
        open_next      = open_reg;
        active_next    = active_reg;
        used_next      = used_reg;
        captot_next    = captot_reg;
        fv_next        = fv_reg;
        scan_addr_next = scan_addr_reg;
        v1_next        = v1_reg;
        v2_next        = v2_reg;
        case (cmd.op)
            OP_PREP:
            begin
                scan_addr_next = CNT_W'(active_reg);
                v1_next        = 1'b0;
                v2_next        = 1'b0;
            end
            OP_SCAN:
            begin
                if (!addr_done)
                begin
                    scan_addr_next = scan_addr_reg + CNT_W'(1);
                    v1_next        = 1'b1;
                end
                else
                begin
                    v1_next = 1'b0;
                end
                v2_next = v1_reg;
            end
            OP_REWIND:
            begin
                fv_next     = '0;
                active_next = '0;
                used_next   = '0;
            end
            OP_RELEASE:
            begin
                open_next   = '0;
                active_next = '0;
                used_next   = '0;
                captot_next = '0;
            end
            OP_GRANT:
            begin
                // The scan pipeline empties so no stale hit survives the grant.
                fv_next[idx2_reg] = 1'b1;
                active_next       = idx2_reg;
                used_next         = used_reg + TOT_W'(size_reg);
                v1_next           = 1'b0;
                v2_next           = 1'b0;
            end
            OP_FRESH:
            begin
                fv_next[new_idx] = 1'b1;
                open_next        = open_reg + CNT_W'(1);
                active_next      = new_idx;
                used_next        = used_reg + TOT_W'(size_reg);
                captot_next      = captot_reg + TOT_W'(want_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= '0;
            active_reg    <= '0;
            used_reg      <= '0;
            captot_reg    <= '0;
            fv_reg        <= '0;
            scan_addr_reg <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
        end
        else
        begin
            open_reg      <= open_next;
            active_reg    <= active_next;
            used_reg      <= used_next;
            captot_reg    <= captot_next;
            fv_reg        <= fv_next;
            scan_addr_reg <= scan_addr_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
        end
    end

    // Request capture and per-request precomputation.
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            type_reg  <= req_type_t'(req_type);
            size_reg  <= (req_size == '0) ? SIZE_W'(1) : req_size;
            align_reg <= req_align;
        end
        if (cmd.op == OP_PREP)
        begin
            mask_reg <= mask_calc;
            want_reg <= want_calc;
        end
    end

    // Single write port into the fill table.
    always_comb
    begin
        fill_wr_en   = 1'b0;
        fill_wr_addr = idx2_reg;
        fill_wr_data = end_sum[SIZE_W-1:0];
        if (cmd.op == OP_GRANT)
        begin
            fill_wr_en = 1'b1;
        end
        else if (cmd.op == OP_FRESH)
        begin
            fill_wr_en   = 1'b1;
            fill_wr_addr = new_idx;
            fill_wr_data = size_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_SCAN && !addr_done)
        begin
            cap1_reg  <= cap_mem[rd_idx];
            fill1_reg <= fill_mem[rd_idx];
            fv1_reg   <= fv_reg[rd_idx];
            idx1_reg  <= rd_idx;
        end
        if (cmd.op == OP_SCAN)
        begin
            o2_reg   <= o_calc;
            cap2_reg <= cap1_reg;
            idx2_reg <= idx1_reg;
        end
        if (fill_wr_en)
        begin
            fill_mem[fill_wr_addr] <= fill_wr_data;
        end
        if (cmd.op == OP_FRESH)
        begin
            cap_mem[new_idx] <= want_reg;
        end
    end

    // Result capture on every committing operation.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_GRANT:
            begin
                status_reg <= ST_OK;
                bidx_reg   <= idx2_reg;
                off_reg    <= o2_reg;
            end
            OP_FRESH:
            begin
                status_reg <= ST_OK;
                bidx_reg   <= new_idx;
                off_reg    <= '0;
            end
            OP_REWIND, OP_RELEASE, OP_NOP:
            begin
                status_reg <= ST_OK;
                bidx_reg   <= '0;
                off_reg    <= '0;
            end
            OP_ALIGN_ERR:
            begin
                status_reg <= ST_ALIGN;
                bidx_reg   <= '0;
                off_reg    <= '0;
            end
            OP_LIMIT_ERR:
            begin
                status_reg <= ST_LIMIT;
                bidx_reg   <= '0;
                off_reg    <= '0;
            end
            OP_FULL_ERR:
            begin
                status_reg <= ST_FULL;
                bidx_reg   <= '0;
                off_reg    <= '0;
            end
            default:
            begin
            end
        endcase
    end

    assign bidx_ext       = {4'b0000, bidx_reg};
    assign status         = status_reg;
    assign block_index    = bidx_ext[BIDX_W-1:0];
    assign region_offset  = off_reg;
    assign bytes_in_use   = used_reg;
    assign total_capacity = captot_reg;

    `ABA_ASSERT(a_hit_in_table, clk, rst_n, hit |-> CNT_W'(idx2_reg) < open_reg, "hit on a closed block")
    `ABA_ASSERT_NEXT(a_grant_used, clk, rst_n, cmd.op == OP_GRANT, used_reg == $past(used_reg) + TOT_W'(size_reg), "grant total mismatch")
    `ABA_ASSERT(a_open_bound, clk, rst_n, open_reg <= CNT_W'(MAX_BLOCKS), "open count above table size")

endmodule

`default_nettype wire

[rtl/arena_bump_allocator_top.sv]
// Top level of the arena bump allocator: configuration port, sequencer
// and datapath. Depends on aba_pkg, aba_ctrl and aba_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Channel        Direction  Handshake                       Payload
// request        in         start high while busy low       req_type, req_size, req_align
// result         out        done, one cycle, no backpressure status, block_index,
//                                                           region_offset, bytes_in_use,
//                                                           total_capacity
// configuration  in/out     psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// Rewind, release, an unknown request type and a refused alignment commit straight
// from decode. An allocate goes on to scan the table from the active block up to the
// last open block and commits on the first entry that fits, or after the whole scan
// on a miss; the scan pipeline reads one table entry per cycle.
// Reset puts the table empty with block_size at 4096; no clearing pass is needed.
// The result receiver cannot stall; done is high for exactly one cycle per
// transaction.

module arena_bump_allocator_top #(
    parameter int          MAX_BLOCKS = aba_pkg::DEF_MAX_BLOCKS,
    parameter int          MAX_ALIGN  = aba_pkg::DEF_MAX_ALIGN,
    parameter logic [31:0] MAX_ALLOC  = aba_pkg::DEF_MAX_ALLOC
) (
    input  wire                            clk,
    input  wire                            rst_n,
    // Request channel.
    input  wire                            start,
    output logic                           busy,
    input  wire  [1:0]                     req_type,
    input  wire  [aba_pkg::SIZE_W-1:0]     req_size,
    input  wire  [aba_pkg::SIZE_W-1:0]     req_align,
    // Result channel.
    output logic                           done,
    output logic [1:0]                     status,
    output logic [aba_pkg::BIDX_W-1:0]     block_index,
    output logic [aba_pkg::SIZE_W-1:0]     region_offset,
    output logic [aba_pkg::TOT_W-1:0]      bytes_in_use,
    output logic [aba_pkg::TOT_W-1:0]      total_capacity,
    // Configuration port.
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [aba_pkg::PADDR_W-1:0]    paddr,
    input  wire  [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import aba_pkg::*;

    logic [SIZE_W-1:0] block_size_reg;
    logic [SIZE_W-1:0] block_size_next;
    logic [0:0]        cfg_idx;
    logic              cfg_wr;
    dp_cmd_t           cmd;
    dp_sts_t           sts;
    status_t           status_w;

    // The configuration port never inserts wait states. The register index
    // is the word address; writes to any other word are dropped and read
    // back as zero.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        block_size_next = block_size_reg;
        if (cfg_wr && cfg_idx == REG_BLOCK_SIZE)
        begin
            block_size_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= BLOCK_SIZE_RST;
        end
        else
        begin
            block_size_reg <= block_size_next;
        end
    end

    assign prdata = (cfg_idx == REG_BLOCK_SIZE) ? block_size_reg : '0;

    // The sequencer walks each transaction through decode, scan and commit;
    // the datapath holds the block tables and totals and reports back the
    // decode and scan outcome.
    aba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    aba_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .MAX_ALIGN  (MAX_ALIGN),
        .MAX_ALLOC  (MAX_ALLOC)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .req_type       (req_type),
        .req_size       (req_size),
        .req_align      (req_align),
        .block_size     (block_size_reg),
        .status         (status_w),
        .block_index    (block_index),
        .region_offset  (region_offset),
        .bytes_in_use   (bytes_in_use),
        .total_capacity (total_capacity)
    );

    assign status = status_w;

endmodule

`default_nettype wire
